// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/wss_pkg.sv -----
// Constants and codes for the weighted slot selector.
package wss_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W      = 64;
  localparam int DIV_W       = $clog2(WORD_W);
  localparam int SLOT_SHIFT  = 32;
  localparam int IN_DATA_W   = 200;
  localparam int OUT_DATA_W  = 8;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
endpackage

// ----- hw/rtl/weighted_slot_selector.sv -----
// Weighted roulette selector over a table of sixteen 64-bit weights.
// A write word stores its weight, updates the running total and then loads the result register.
// A select word sums the participating entries from the weight RAM, then runs restoring
// division for slot modulo sum, then walks the entries, and last loads the result register.
// A select with no entries goes straight to the result, and one with a zero total stops
// after the sum. The weight RAM gives a single read per cycle and the divider one bit per cycle.
// One word is processed at a time. The next word can be taken in the cycle after the result
// register is loaded, and the result register lets it in while a result waits. Reset clears the
// table through per-entry valid bits, so there is no clearing pass.
`include "assert_macros.svh"

module weighted_slot_selector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [wss_pkg::CNT_W-1:0]      cfg_wdata,   // entry_count
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // index[3:0], weight[67:4], epoch[131:68], height[195:132], zero fill
  input  logic [wss_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,     // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // chosen[3:0], status[5:4], zero fill
  output logic [wss_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int W  = wss_pkg::WORD_W;
  localparam int IW = wss_pkg::IDX_W;
  localparam int CW = wss_pkg::CNT_W;

  logic [2:0]    state;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] n;
  logic [CW-1:0] cnt;
  logic          dv;
  logic [IW-1:0] didx;
  logic          found;
  logic [IW-1:0] pick;
  logic [W-1:0]  rem;
  logic [W-1:0]  sum;
  logic [W-1:0]  operand;
  logic [IW-1:0] wr_idx;
  logic [wss_pkg::DIV_W-1:0] bitcnt;
  logic [W-1:0]  weight_total;
  logic [IW-1:0] res_chosen;
  logic [1:0]    res_status;

  logic [W-1:0]  mem [wss_pkg::MAX_ENTRIES];
  logic [wss_pkg::MAX_ENTRIES-1:0] valid;
  logic [W-1:0]  rdata;
  logic          rvld;

  logic [IW-1:0] raddr;
  logic [W-1:0]  rword;
  logic          wr_en;
  logic [CW-1:0] cfg_sat;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;
  logic          out_free;

  logic [IW-1:0] in_index;
  logic [W-1:0]  in_weight;
  logic [W-1:0]  in_epoch;
  logic [W-1:0]  in_height;

  assign in_index  = s_tdata[IW-1:0];
  assign in_weight = s_tdata[IW +: W];
  assign in_epoch  = s_tdata[IW+W +: W];
  assign in_height = s_tdata[IW+2*W +: W];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign wr_en    = (state == S_WR);
  assign raddr    = (state == S_IDLE) ? in_index : cnt[IW-1:0];
  assign rword    = rvld ? rdata : '0;
  assign cfg_sat  = (entry_count > CW'(wss_pkg::MAX_ENTRIES)) ?
                    CW'(wss_pkg::MAX_ENTRIES) : entry_count;
  assign rem_sh   = {rem, operand[W-1]};
  assign rem_diff = rem_sh - {1'b0, sum};

  // weight RAM, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= operand;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rvld  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      rvld <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wen) begin
      entry_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      dv           <= 1'b0;
      found        <= 1'b0;
      weight_total <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n      <= cfg_sat;
            wr_idx <= in_index;
            if (s_tuser == wss_pkg::FUNC_WRITE) begin
              operand <= in_weight;
              state   <= S_WR;
            end else if (cfg_sat == '0) begin
              res_chosen <= '0;
              res_status <= wss_pkg::ST_EMPTY;
              state      <= S_DONE;
            end else begin
              operand <= (in_epoch << wss_pkg::SLOT_SHIFT) ^ in_height;
              cnt     <= '0;
              dv      <= 1'b0;
              sum     <= '0;
              state   <= S_SUM;
            end
          end
        end
        S_WR: begin
          // old weight arrives from the RAM this cycle
          weight_total <= weight_total - rword + operand;
          res_chosen   <= '0;
          res_status   <= wss_pkg::ST_OK;
          state        <= S_DONE;
        end
        S_SUM: begin
          dv   <= (cnt < n);
          didx <= cnt[IW-1:0];
          if (cnt < n) begin
            cnt <= cnt + CW'(1);
          end
          if (dv) begin
            sum <= sum + rword;
          end
          if (cnt == n && !dv) begin
            if (sum == '0) begin
              res_chosen <= '0;
              res_status <= wss_pkg::ST_ZERO;
              state      <= S_DONE;
            end else begin
              rem    <= '0;
              bitcnt <= '0;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division, one slot bit per cycle, most significant first
          operand <= {operand[W-2:0], 1'b0};
          if (!rem_diff[W]) begin
            rem <= rem_diff[W-1:0];
          end else begin
            rem <= rem_sh[W-1:0];
          end
          bitcnt <= bitcnt + wss_pkg::DIV_W'(1);
          if (bitcnt == wss_pkg::DIV_W'(W - 1)) begin
            cnt   <= '0;
            dv    <= 1'b0;
            found <= 1'b0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          dv   <= (cnt < n);
          didx <= cnt[IW-1:0];
          if (cnt < n) begin
            cnt <= cnt + CW'(1);
          end
          if (dv && !found) begin
            if (rem < rword) begin
              found <= 1'b1;
              pick  <= didx;
            end else begin
              rem <= rem - rword;
            end
          end
          if (cnt == n && !dv) begin
            // no hit falls back to the last participating entry
            res_chosen <= found ? pick : IW'(n - CW'(1));
            res_status <= wss_pkg::ST_OK;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {{(wss_pkg::OUT_DATA_W - IW - 2){1'b0}}, res_status, res_chosen};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rem_below_sum, clk, rst, state != S_DIV || rem < sum)
  `ASSERT_ALWAYS(a_walk_count, clk, rst, (state != S_WALK && state != S_SUM) || cnt <= n)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, s_tvalid && s_tready, state != S_IDLE)
  `ASSERT_IMPLIES(a_zero_status_sum, clk, rst, state == S_DONE && res_status == wss_pkg::ST_ZERO, sum == '0)

endmodule
